>>> sv/shstep_pkg.sv
// Shared types, constants and the half-step phase table for the stepper
// travel driver. No dependencies.
package shstep_pkg;

  localparam logic [7:0]  SPEED_DIV_RST  = 8'd5;
  localparam logic [15:0] STEP_LIMIT_RST = 16'd2048;

  localparam logic       ACT_TICK = 1'b0;
  localparam logic       ACT_SET  = 1'b1;

  localparam int unsigned REG_ADDR_W = 3;
  localparam logic        REG_SPEED_DIV  = 1'b0;
  localparam logic        REG_STEP_LIMIT = 1'b1;

  typedef struct packed {
    logic [15:0] position;
    logic [7:0]  prescale;
    logic        fwd_active;
    logic        rev_active;
    logic        end_reached;
    logic [3:0]  coils;
  } shstep_state_t;

  function automatic logic [3:0] phase_coils(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

>>> sv/shstep_step.sv
// Next-state logic for one transfer of the stepper travel driver.
// Depends on shstep_pkg.
module shstep_step (
  input  shstep_pkg::shstep_state_t state,
  input  logic                      action,
  input  logic                      forward_request,
  input  logic                      reverse_request,
  input  logic [7:0]                speed_div,
  input  logic [15:0]               step_limit,
  output shstep_pkg::shstep_state_t state_nxt
);

  logic [7:0] pre_inc;
  logic       due;

  assign pre_inc = state.prescale + 8'd1;
  assign due     = pre_inc > speed_div;

  always_comb begin
    state_nxt = state;
    if (action == shstep_pkg::ACT_SET) begin
      state_nxt.fwd_active = forward_request;
      state_nxt.rev_active = reverse_request;
    end else begin
      state_nxt.coils = shstep_pkg::phase_coils(state.position[2:0]);
      if (state.fwd_active) begin
        state_nxt.prescale = due ? 8'd0 : pre_inc;
        if (due) begin
          if (state.position < step_limit) begin
            state_nxt.position = state.position + 16'd1;
          end else begin
            state_nxt.fwd_active  = 1'b0;
            state_nxt.end_reached = 1'b1;
          end
        end
      end else if (state.rev_active) begin
        state_nxt.prescale = due ? 8'd0 : pre_inc;
        if (due) begin
          if (state.position != 16'd0) begin
            state_nxt.position = state.position - 16'd1;
          end else begin
            state_nxt.rev_active  = 1'b0;
            state_nxt.end_reached = 1'b0;
          end
        end
      end else begin
        state_nxt.prescale = 8'd0;
        state_nxt.coils    = 4'h0;
      end
    end
  end

endmodule

>>> sv/stepper_half_step_travel_driver_core.sv
// Top level of the half-step stepper travel driver: input register,
// travel state, result register and APB register file. Uses shstep_pkg, shstep_step.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: a timer
//   tick (in_action = 0) or a write of the travel request flags (in_action = 1).
//   Every item yields exactly one result on the out_ channel: coil pattern,
//   position, at-end flag and the two travel busy flags after that item.
//   The input register holds each item and the result register takes its next
//   state; one item is taken every cycle while out_stall is low, set by the
//   single register stage on each side of the next-state logic.
//   When out_stall is high the result holds, the travel state holds and the
//   input register keeps one further item; in_stall rises once it is full.
//   Reset (rst_n low, synchronous) empties both registers, clears position,
//   prescaler, flags and coils, and loads speed_divider = 5, step_limit = 2048.
//   Registers: speed_divider at byte address 0, step_limit at address 4;
//   write only while no item is in flight. pready is always high.
module stepper_half_step_travel_driver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic        in_forward_request,
  input  logic        in_reverse_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_coil_pattern,
  output logic [15:0] out_position_now,
  output logic        out_at_end,
  output logic        out_forward_busy,
  output logic        out_reverse_busy,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [shstep_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  shstep_pkg::shstep_state_t state_r, state_nxt;
  logic        in_vld_r;
  logic        in_action_r, in_fwd_r, in_rev_r;
  logic        out_vld_r;
  logic [7:0]  speed_div_r;
  logic [15:0] step_limit_r;
  logic        adv;
  logic        in_take;
  logic        cfg_wr;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  shstep_step u_step (
    .state           (state_r),
    .action          (in_action_r),
    .forward_request (in_fwd_r),
    .reverse_request (in_rev_r),
    .speed_div       (speed_div_r),
    .step_limit      (step_limit_r),
    .state_nxt       (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= in_action;
      in_fwd_r    <= in_forward_request;
      in_rev_r    <= in_reverse_request;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_div_r  <= shstep_pkg::SPEED_DIV_RST;
      step_limit_r <= shstep_pkg::STEP_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        shstep_pkg::REG_SPEED_DIV:  speed_div_r  <= pwdata[7:0];
        shstep_pkg::REG_STEP_LIMIT: step_limit_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      shstep_pkg::REG_SPEED_DIV:  prdata = {24'd0, speed_div_r};
      shstep_pkg::REG_STEP_LIMIT: prdata = {16'd0, step_limit_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign out_valid        = out_vld_r;
  assign out_coil_pattern = state_r.coils;
  assign out_position_now = state_r.position;
  assign out_at_end       = state_r.end_reached;
  assign out_forward_busy = state_r.fwd_active;
  assign out_reverse_busy = state_r.rev_active;

`ifndef NO_ASSERTIONS
  a_step_size: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (state_nxt.position == state_r.position) ||
            (state_nxt.position == state_r.position + 16'd1) ||
            (state_nxt.position == state_r.position - 16'd1))
    else $error("position moved by more than one half-step");

  a_fwd_limit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && state_nxt.position == state_r.position + 16'd1 |->
      state_r.position < step_limit_r)
    else $error("position advanced at or past step limit");

  a_idle_coils: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_action_r == shstep_pkg::ACT_TICK && !state_r.fwd_active &&
      !state_r.rev_active |=> state_r.coils == 4'h0 && state_r.prescale == 8'd0)
    else $error("idle tick left coils driven or prescaler running");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> $stable(state_r))
    else $error("travel state changed while result stalled");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a held item");
`endif

endmodule
